[sv/fra_pkg.sv]
// ---------------------------------------------------------------------------
// fra_pkg: shared types and constants for the frame rate averager
// Default window, field widths, register reset value, result limit, command codes and sequencer states.
// ---------------------------------------------------------------------------
package fra_pkg;

   // default averaging window, in intervals
   localparam int WINDOW_DEFAULT = 8;

   // field widths
   localparam int TS_W      = 32;
   localparam int TPS_W     = 20;
   localparam int RATE_W    = 31;
   localparam int SAMPLES_W = 4;
   localparam int FRAC_W    = 8;

   // register reset and result limit
   localparam logic [TPS_W-1:0]  TPS_RESET = 20'd1000;
   localparam logic [RATE_W-1:0] RATE_MAX  = 31'h7FFF_FFFF;

   // command codes carried on req_tuser
   localparam logic CMD_RESTART = 1'b0;
   localparam logic CMD_MARK    = 1'b1;

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RETIRE,
      ST_ACCUM,
      ST_SCALE,
      ST_DIVIDE,
      ST_FINISH
   } fra_state_type;

endpackage

[sv/fra_ram.sv]
// ---------------------------------------------------------------------------
// fra_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ---------------------------------------------------------------------------
module fra_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/frame_rate_averager.sv]
// ---------------------------------------------------------------------------
// frame_rate_averager: moving-average frame rate meter
// Averages the last WINDOW mark-to-mark intervals and reports the rate in Q.8.
// ---------------------------------------------------------------------------
// Usage:
//  req channel: tuser is the command (restart or frame mark), tdata the
//  32-bit timestamp. A restart beat re-arms the meter at its timestamp and
//  gives no result. A frame mark beat gives one rsp beat.
//  rsp channel: tdata holds rate_q8 (ticks_per_second*256*count/sum,
//  truncated, saturated) and samples_used; tuser flags a zero interval sum,
//  in which case the rate reads as its maximum.
//  csr port: csr_we writes ticks_per_second from csr_wdata; write only
//  while the block is idle.
// Sequence: a restart is taken in the idle state and the block stays idle.
//  A frame mark runs a ring read, a subtract, an add, one scale multiply,
//  then a restoring divider that resolves one quotient bit per cycle, and
//  a finish step that loads the rsp beat. req_tready is low meanwhile.
//  A zero sum skips the divider.
// The interval ring is a RAM; it needs no clearing, since an entry's value
//  is used only once the window has filled since the last restart.
// Reset clears the sum, count, slot, last mark and the output beat, and
//  loads ticks_per_second with 1000. A stalled rsp beat is held in the
//  output register; the next mark waits in the last step until it drains.
// ---------------------------------------------------------------------------
module frame_rate_averager #(
   parameter int WINDOW = fra_pkg::WINDOW_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   // config
   input  logic                        csr_we,
   input  logic [fra_pkg::TPS_W-1:0]   csr_wdata,   // ticks_per_second
   // request stream
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [31:0]                 req_tdata,   // [31:0] timestamp
   input  logic                        req_tuser,   // [0] command
   // response stream
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [39:0]                 rsp_tdata,   // [30:0] rate_q8,
                                                    // [34:31] samples_used,
                                                    // [39:35] zero pad
   output logic                        rsp_tuser    // [0] zero_interval
);

   import fra_pkg::*;

   localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int CNT_W  = $clog2(WINDOW + 1);
   localparam int SUM_W  = TS_W + $clog2(WINDOW);
   localparam int PROD_W = TPS_W + CNT_W;
   localparam int NUM_W  = (PROD_W + FRAC_W > RATE_W) ? PROD_W + FRAC_W : RATE_W + 1;
   localparam int DCNT_W = $clog2(NUM_W);
   localparam logic [CNT_W-1:0]  WIN_CNT  = CNT_W'(WINDOW);
   localparam logic [SLOT_W-1:0] SLOT_TOP = SLOT_W'(WINDOW - 1);

   fra_state_type state_ff, state_in;

   logic [TPS_W-1:0]     tps_ff;
   logic [TS_W-1:0]      last_mark_ff, last_mark_in;
   logic [SLOT_W-1:0]    slot_ff, slot_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [SUM_W-1:0]     sum_ff, sum_in;
   logic [TS_W-1:0]      interval_ff, interval_in;
   logic [NUM_W-1:0]     num_ff, num_in;
   logic [SUM_W-1:0]     rem_ff, rem_in;
   logic [DCNT_W-1:0]    div_cnt_ff, div_cnt_in;
   logic                 zero_ff, zero_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [RATE_W-1:0]    rsp_rate_ff, rsp_rate_in;
   logic [SAMPLES_W-1:0] rsp_samples_ff, rsp_samples_in;
   logic                 rsp_zero_ff, rsp_zero_in;

   logic                 req_beat;
   logic                 ram_wr_en;
   logic                 ram_rd_en;
   logic [TS_W-1:0]      ram_rd_data;
   logic [PROD_W-1:0]    prod;
   logic [SUM_W:0]       trial;
   logic [SUM_W:0]       diff;
   logic                 q_bit;
   logic [SAMPLES_W+CNT_W-1:0] samples_wide;

   // interval ring
   fra_ram #(
      .WIDTH (TS_W),
      .DEPTH (WINDOW)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (slot_ff),
      .wr_data (interval_ff),
      .rd_en   (ram_rd_en),
      .rd_addr (slot_ff),
      .rd_data (ram_rd_data)
   );

   // shared datapath pieces
   assign prod         = PROD_W'(tps_ff) * PROD_W'(count_ff);
   assign trial        = {rem_ff, num_ff[NUM_W-1]};
   assign diff         = trial - {1'b0, sum_ff};
   assign q_bit        = ~diff[SUM_W];
   assign samples_wide = {{SAMPLES_W{1'b0}}, count_ff};

   assign req_tready = (state_ff == ST_IDLE);
   assign req_beat   = req_tvalid & req_tready;

   // sequencer: next state and datapath control
   always_comb begin
      state_in       = state_ff;
      last_mark_in   = last_mark_ff;
      slot_in        = slot_ff;
      count_in       = count_ff;
      sum_in         = sum_ff;
      interval_in    = interval_ff;
      num_in         = num_ff;
      rem_in         = rem_ff;
      div_cnt_in     = div_cnt_ff;
      zero_in        = zero_ff;
      rsp_valid_in   = rsp_valid_ff & ~rsp_tready;
      rsp_rate_in    = rsp_rate_ff;
      rsp_samples_in = rsp_samples_ff;
      rsp_zero_in    = rsp_zero_ff;
      ram_wr_en      = 1'b0;
      ram_rd_en      = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_beat) begin
               last_mark_in = req_tdata;
               if (req_tuser == CMD_RESTART) begin
                  count_in = '0;
                  slot_in  = '0;
                  sum_in   = '0;
               end else begin
                  // fetch the oldest entry while the interval is taken
                  interval_in = req_tdata - last_mark_ff;
                  ram_rd_en   = 1'b1;
                  state_in    = ST_RETIRE;
               end
            end
         end
         ST_RETIRE: begin
            if (count_ff >= WIN_CNT) begin
               sum_in = sum_ff - SUM_W'(ram_rd_data);
            end else begin
               count_in = count_ff + 1'b1;
            end
            state_in = ST_ACCUM;
         end
         ST_ACCUM: begin
            sum_in    = sum_ff + SUM_W'(interval_ff);
            ram_wr_en = 1'b1;
            slot_in   = (slot_ff == SLOT_TOP) ? '0 : slot_ff + 1'b1;
            state_in  = ST_SCALE;
         end
         ST_SCALE: begin
            // numerator = ticks_per_second * count * 256
            num_in     = NUM_W'({prod, {FRAC_W{1'b0}}});
            rem_in     = '0;
            div_cnt_in = DCNT_W'(NUM_W - 1);
            zero_in    = (sum_ff == '0);
            state_in   = (sum_ff == '0) ? ST_FINISH : ST_DIVIDE;
         end
         ST_DIVIDE: begin
            // one restoring step; quotient shifts into num from the bottom
            rem_in = q_bit ? diff[SUM_W-1:0] : trial[SUM_W-1:0];
            num_in = {num_ff[NUM_W-2:0], q_bit};
            if (div_cnt_ff == '0) begin
               state_in = ST_FINISH;
            end else begin
               div_cnt_in = div_cnt_ff - 1'b1;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in   = 1'b1;
               rsp_zero_in    = zero_ff;
               rsp_samples_in = samples_wide[SAMPLES_W-1:0];
               if (zero_ff || (|num_ff[NUM_W-1:RATE_W])) begin
                  rsp_rate_in = RATE_MAX;
               end else begin
                  rsp_rate_in = num_ff[RATE_W-1:0];
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         tps_ff       <= TPS_RESET;
         last_mark_ff <= '0;
         slot_ff      <= '0;
         count_ff     <= '0;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         last_mark_ff <= last_mark_in;
         slot_ff      <= slot_in;
         count_ff     <= count_in;
         sum_ff       <= sum_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            tps_ff <= csr_wdata;
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      interval_ff    <= interval_in;
      num_ff         <= num_in;
      rem_ff         <= rem_in;
      div_cnt_ff     <= div_cnt_in;
      zero_ff        <= zero_in;
      rsp_rate_ff    <= rsp_rate_in;
      rsp_samples_ff <= rsp_samples_in;
      rsp_zero_ff    <= rsp_zero_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b0, rsp_samples_ff, rsp_rate_ff};
   assign rsp_tuser  = rsp_zero_ff;

   // count saturates at the window size
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= WIN_CNT)
      else $error("valid count above window");

   // a zero sum always reports the saturated rate
   a_zero_rate: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> (rsp_tdata[RATE_W-1:0] == RATE_MAX))
      else $error("zero interval without saturated rate");

   // a restart never produces a response beat
   a_restart_silent: assert property (@(posedge clock) disable iff (reset)
      (req_beat && (req_tuser == CMD_RESTART) && !rsp_tvalid) |=> !rsp_tvalid)
      else $error("response after restart");

endmodule

[tb/sv/frame_rate_averager_tb.sv]
// ---------------------------------------------------------------------------
// frame_rate_averager_tb: self-checking bench for the frame rate averager
// Drives restart and frame mark beats with random gaps and back-pressure.
// It predicts every rate beat from its own copy of the window state and
// compares each rsp beat, field by field, against the oldest prediction.
// The clock-rate register is swept between phases, extremes included.
// ---------------------------------------------------------------------------
module frame_rate_averager_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import fra_pkg::*;

   localparam int          WIN          = WINDOW_DEFAULT;
   localparam int          DRAIN_CYCLES = 60;      // mark latency plus margin
   localparam int          LONG_HOLD    = 400;     // long rsp stall, in cycles
   localparam int          PHASES       = 7;
   localparam int          PHASE_ITEMS  = 100;
   localparam int unsigned CYCLE_LIMIT  = 400000;

   // one predicted rsp beat
   typedef struct packed {
      logic [RATE_W-1:0]    rate;
      logic [SAMPLES_W-1:0] samples;
      logic                 zero_flag;
   } rate_result_type;

   // window state copy, predicted rates and the rsp comparison
   class rate_scoreboard_type;
      logic [TPS_W-1:0] ticks;
      logic [TS_W-1:0]  last_mark;
      logic [TS_W-1:0]  ring [WIN];
      int unsigned      slot;
      int unsigned      count;
      logic [63:0]      sum;
      rate_result_type  pending_rates [$];
      int unsigned      errors;

      function new();
         ticks     = TPS_RESET;
         last_mark = '0;
         slot      = 0;
         count     = 0;
         sum       = '0;
         errors    = 0;
      endfunction

      // note one accepted req beat
      function void note_beat(logic cmd, logic [TS_W-1:0] ts);
         logic [TS_W-1:0] gap;
         logic [63:0]     quotient;
         rate_result_type res;
         if (cmd == CMD_RESTART) begin
            last_mark = ts;
            count     = 0;
            slot      = 0;
            sum       = '0;
            return;
         end
         gap       = ts - last_mark;
         last_mark = ts;
         // full window: oldest interval leaves the sum
         if (count >= WIN) begin
            sum = sum - 64'(ring[slot]);
         end else begin
            count++;
         end
         ring[slot] = gap;
         sum        = sum + 64'(gap);
         slot       = (slot + 1) % WIN;
         if (sum == 0) begin
            res.rate      = RATE_MAX;
            res.zero_flag = 1'b1;
         end else begin
            quotient      = (64'(ticks) * 64'd256 * 64'(count)) / sum;
            res.rate      = (quotient > 64'(RATE_MAX)) ? RATE_MAX : quotient[RATE_W-1:0];
            res.zero_flag = 1'b0;
         end
         res.samples = count[SAMPLES_W-1:0];
         pending_rates.push_back(res);
      endfunction

      // compare one accepted rsp beat with the oldest prediction
      function void check_rate(logic [39:0] data, logic flag);
         rate_result_type want;
         if (pending_rates.size() == 0) begin
            $error("rsp beat with no rate pending: tdata=%h tuser=%b", data, flag);
            errors++;
            return;
         end
         want = pending_rates.pop_front();
         if (data[RATE_W-1:0] !== want.rate) begin
            $error("rate_q8 mismatch: expected %0d, actual %0d", want.rate,
                   data[RATE_W-1:0]);
            errors++;
         end
         if (data[RATE_W+SAMPLES_W-1:RATE_W] !== want.samples) begin
            $error("samples_used mismatch: expected %0d, actual %0d", want.samples,
                   data[RATE_W+SAMPLES_W-1:RATE_W]);
            errors++;
         end
         if (flag !== want.zero_flag) begin
            $error("zero_interval mismatch: expected %0b, actual %0b", want.zero_flag,
                   flag);
            errors++;
         end
      endfunction
   endclass

   logic               clock      = 1'b0;
   logic               reset      = 1'b1;
   logic               csr_we     = 1'b0;
   logic [TPS_W-1:0]   csr_wdata  = '0;
   logic               req_tvalid = 1'b0;
   logic               req_tready;
   logic [31:0]        req_tdata  = '0;
   logic               req_tuser  = CMD_MARK;
   logic               rsp_tvalid;
   logic               rsp_tready = 1'b0;
   logic [39:0]        rsp_tdata;
   logic               rsp_tuser;

   rate_scoreboard_type sb = new();
   logic [TS_W-1:0]    ts_cursor = '0;   // last timestamp sent
   bit                 quiet = 1'b0;     // no idling on either side
   bit                 long_hold_req = 1'b0;

   frame_rate_averager uut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // 8 ns clock
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // offer one req beat, maybe after a gap, and wait for its acceptance
   task automatic send_beat(input logic cmd, input logic [TS_W-1:0] ts);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= ts;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_beat(cmd, ts);
      ts_cursor = ts;
   endtask

   // stop offering until every rate beat is back and the block has settled
   task automatic drain_block();
      req_tvalid <= 1'b0;
      while (sb.pending_rates.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // rsp side: check beats, stall in random bursts or one long hold
   initial begin : rsp_sink
      int unsigned stall_left;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) begin
            sb.check_rate(rsp_tdata, rsp_tuser);
         end
         if (long_hold_req) begin
            long_hold_req = 1'b0;
            stall_left    = LONG_HOLD;
         end
         if (stall_left != 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else if (!quiet && $urandom_range(0, 5) == 0) begin
            rsp_tready <= 1'b0;
            stall_left = $urandom_range(1, 17) - 1;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // run limit
   initial begin : watchdog
      int unsigned cycle_count;
      for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++) begin
         @(posedge clock);
      end
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // stimulus
   initial begin : stimulus
      logic [TPS_W-1:0] tps_plan [PHASES];
      logic [TS_W-1:0]  gap;
      int               p;
      int               n;
      int unsigned      pick;

      tps_plan[0] = 20'd1;
      tps_plan[1] = 20'd1000000;
      tps_plan[2] = 20'hFFFFF;
      tps_plan[3] = 20'd0;
      tps_plan[4] = TPS_W'($urandom_range(1, 1000000));
      tps_plan[5] = TPS_W'($urandom_range(1, 1000000));
      tps_plan[6] = TPS_RESET;

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part, register at its reset value
      send_beat(CMD_MARK, 32'd0);              // zero interval straight after reset
      send_beat(CMD_MARK, 32'd1000);
      send_beat(CMD_RESTART, 32'hFFFF_FFF0);
      send_beat(CMD_MARK, 32'h0000_0010);      // interval wraps through zero
      for (n = 0; n < 9; n++) begin            // fill window, then replace oldest
         send_beat(CMD_MARK, ts_cursor + 32'd100);
      end
      send_beat(CMD_RESTART, 32'hFFFF_FFFF);
      send_beat(CMD_MARK, 32'hFFFF_FFFF);      // zero sum, one sample
      send_beat(CMD_MARK, 32'hFFFF_FFFF);      // zero sum, two samples
      send_beat(CMD_MARK, 32'hFFFF_FFFE);      // largest interval
      send_beat(CMD_RESTART, 32'd0);
      send_beat(CMD_RESTART, 32'd5);           // restart right after restart
      send_beat(CMD_MARK, 32'd5);
      send_beat(CMD_MARK, 32'd6);

      // random phases, one register setting each
      for (p = 0; p < PHASES; p++) begin
         drain_block();
         quiet = (p == PHASES - 1);
         csr_we    <= 1'b1;
         csr_wdata <= tps_plan[p];
         @(posedge clock);
         csr_we    <= 1'b0;
         sb.ticks = tps_plan[p];
         for (n = 0; n < PHASE_ITEMS; n++) begin
            if (p == 1 && n == 10) long_hold_req = 1'b1;
            if (p == 3 && n == 50) drain_block();
            pick = $urandom_range(0, 99);
            if (pick < 6) begin
               send_beat(CMD_RESTART, $urandom);
            end else if (pick < 10) begin
               send_beat(CMD_MARK, $urandom);     // unrelated timestamp
            end else begin
               case ($urandom_range(0, 9))
                  0:       gap = '0;
                  1, 2, 3,
                  4:       gap = $urandom_range(1, 2000);
                  5, 6:    gap = $urandom_range(1, 2000000);
                  7:       gap = $urandom;
                  default: gap = $urandom_range(0, 3);
               endcase
               send_beat(CMD_MARK, ts_cursor + gap);
            end
         end
      end

      drain_block();
      if (sb.errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

[filelist.f]
sv/fra_pkg.sv
sv/fra_ram.sv
sv/frame_rate_averager.sv
tb/sv/frame_rate_averager_tb.sv
